// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ANY(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/fedbx_pkg.sv -----
// Shared types, constants and the data-word decoder of the event deframer.
// No dependencies.
package fedbx_pkg;

  localparam int CROSSING_BINS_DEF = 4096;
  localparam int COUNT_WIDTH_DEF   = 16;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [31:0] TDC_MARK      = 32'h5333_3333;
  localparam logic [3:0]  TRAILER_NIB   = 4'ha;
  localparam logic [7:0]  TRAILER_BYTE  = 8'ha0;
  localparam logic [7:0]  HEADER_BYTE   = 8'h50;
  localparam logic [31:0] ALL_ONES      = 32'hffff_ffff;
  localparam logic [7:0]  TDC_LIMIT_RST = 8'd100;
  localparam logic [31:0] WRAP_STEP_RST = 32'd86400000;
  localparam logic [31:0] LAST_TIME_RST = 32'hffff_ffff;

  localparam logic OP_STREAM   = 1'b0;
  localparam logic OP_READ     = 1'b1;
  localparam logic KIND_EVENT  = 1'b0;
  localparam logic KIND_READ   = 1'b1;
  localparam logic REG_TDC_SCAN_LIMIT = 1'b0;
  localparam logic REG_TIME_WRAP_STEP = 1'b1;

  typedef enum logic [1:0] {
    MODE_HUNT,
    MODE_TDC,
    MODE_EVENT,
    MODE_SKIP
  } mode_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] stream_word;
    logic [11:0] bin_index;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [11:0] crossing;
    logic [23:0] event_number;
    logic [15:0] hit_count;
    logic [15:0] special_a_count;
    logic [15:0] special_b_count;
    logic [15:0] special_c_count;
    logic [15:0] error_count;
    logic [15:0] data_word_count;
    logic [31:0] event_time;
    logic [31:0] bin_events;
    logic [31:0] bin_hits;
  } res_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] crossing;
    logic [23:0] event_number;
    logic [15:0] hit_count;
    logic [15:0] special_a_count;
    logic [15:0] special_b_count;
    logic [15:0] special_c_count;
    logic [15:0] error_count;
    logic [15:0] data_word_count;
    logic [31:0] event_time;
    logic [31:0] hist_hits;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       hit;
    logic       spa;
    logic       spb;
    logic       spc;
    logic [1:0] err;
  } dec_t;

  function automatic dec_t decode_word(input logic [31:0] w);
    dec_t       d;
    logic [5:0] chan;
    logic [4:0] chip;
    d    = '0;
    chan = w[31:26];
    chip = w[25:21];
    if (w[27:0] == 28'd0) begin
      d.err = 2'd1;
    end else if (chip > 5'd25) begin
      if (w == ALL_ONES) begin
        d.err = 2'd1;
      end else begin
        case (chip) inside
          5'd26, 5'd27: d.spa = 1'b1;
          5'd29:        d.spb = 1'b1;
          5'd31:        d.spc = 1'b1;
          default:      d.err = 2'd1;
        endcase
      end
    end else if (chan > 6'd0 && chan < 6'd37) begin
      if (chip >= 5'd1 && chip <= 5'd3) d.hit = 1'b1;
      else d.err = 2'd1;
    end else begin
      d.err = 2'd2;
    end
    return d;
  endfunction

endpackage

// ----- rtl/fed_event_deframer_bx_histogram.sv -----
// Top level of the event deframer with per-crossing histograms.
// Depends on fedbx_pkg, fedbx_front, fedbx_queue and fedbx_back.
//
// Takes one item per clock while in_ready is high: a readout word (opcode 0) or
// a histogram bin read (opcode 1). The front part pairs words, skips TDC blocks,
// finds headers and trailers and keeps the per-event counts; every item is
// handled in the cycle it is accepted. Trailers and bin reads become jobs in a
// four-entry queue. The back part pops a job into its stage register while
// reading the two 4096-bin histogram memories (one read-modify-write port each),
// updates the event's bin and registers the result in out_data; one item per
// cycle is sustained as long as results are taken. After reset a clearing pass
// zeroes all CROSSING_BINS bins (4096 by default), one bin per cycle; in_ready
// stays low for that time while configuration writes are still taken. Write
// configuration only while the block is idle.
module fed_event_deframer_bx_histogram #(
  parameter int CROSSING_BINS = fedbx_pkg::CROSSING_BINS_DEF,
  parameter int COUNT_WIDTH   = fedbx_pkg::COUNT_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [31:0]     cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  fedbx_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output fedbx_pkg::res_t out_data
);

  logic               take, push, pop, clearing;
  fedbx_pkg::job_t    push_job, pop_job;
  fedbx_pkg::q_stat_t q_stat;

  // Hold off input while clearing or while the queue has no room
  assign in_ready = !clearing && !q_stat.full;
  assign take     = in_valid && in_ready;

  fedbx_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .item      (in_data),
    .push      (push),
    .job       (push_job)
  );

  fedbx_queue #(.DEPTH(fedbx_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .pop_data  (pop_job),
    .stat      (q_stat)
  );

  fedbx_back #(.CROSSING_BINS(CROSSING_BINS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_stat.empty),
    .pop       (pop),
    .job       (pop_job),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/fedbx_front.sv -----
// Front part: pairs stream words, tracks framing, counts data words, builds jobs.
// Depends on fedbx_pkg.
module fedbx_front #(
  parameter int COUNT_WIDTH = fedbx_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic             take,
  input  fedbx_pkg::in_t   item,
  output logic             push,
  output fedbx_pkg::job_t  job
);

  localparam int CW = COUNT_WIDTH;

  fedbx_pkg::mode_t mode, mode_next;
  logic        pair_half, pair_half_next;
  logic [31:0] first_hold, first_hold_next;
  logic [31:0] pend_a, pend_a_next, pend_b, pend_b_next;
  logic        pend_vld, pend_vld_next;
  logic [31:0] prev_a, prev_a_next, prev_b, prev_b_next;
  logic [7:0]  tdc_seen, tdc_seen_next;
  logic [CW-1:0] cnt [5];
  logic [CW-1:0] cnt_next [5];
  logic [CW-1:0] word_cnt, word_cnt_next;
  logic [11:0] cur_xing, cur_xing_next;
  logic [23:0] cur_evt, cur_evt_next;
  logic [31:0] last_time, last_time_next;
  logic [31:0] time_off, time_off_next;
  logic [7:0]  tdc_limit;
  logic [31:0] wrap_step;

  logic        stream, ev_pend, pair_done, fin_pend, fin_a, fin_b, finish;
  logic        tdc_open, hdr;
  logic [31:0] w, fin_time;
  logic [7:0]  tdc_seen_inc;
  fedbx_pkg::dec_t d0, d1;
  logic [2:0]  inc [5];

  function automatic logic [CW-1:0] sat_cnt(input logic [CW-1:0] c, input logic [2:0] n);
    logic [CW:0] s;
    s = {1'b0, c} + (CW+1)'(n);
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  // Classify the word
  always_comb begin
    w         = item.stream_word;
    stream    = take && (item.opcode == fedbx_pkg::OP_STREAM);
    ev_pend   = (mode == fedbx_pkg::MODE_EVENT) && pend_vld;
    pair_done = stream && (mode == fedbx_pkg::MODE_HUNT || mode == fedbx_pkg::MODE_EVENT)
                && !ev_pend && pair_half;
    fin_pend  = stream && ev_pend && (w[31:24] == fedbx_pkg::TRAILER_BYTE);
    fin_b     = pair_done && (mode == fedbx_pkg::MODE_EVENT)
                && (w[31:24] == fedbx_pkg::TRAILER_BYTE);
    fin_a     = pair_done && (mode == fedbx_pkg::MODE_EVENT) && !fin_b
                && (first_hold[31:24] == fedbx_pkg::TRAILER_BYTE);
    finish    = fin_pend || fin_a || fin_b;
    tdc_open  = pair_done && (mode == fedbx_pkg::MODE_HUNT)
                && (first_hold == fedbx_pkg::TDC_MARK) && (w == fedbx_pkg::TDC_MARK);
    hdr       = pair_done && (mode == fedbx_pkg::MODE_HUNT) && !tdc_open
                && (((w[31:24] == fedbx_pkg::HEADER_BYTE) && (first_hold[7:0] == 8'd0))
                 || ((first_hold[31:24] == fedbx_pkg::HEADER_BYTE) && (w[7:0] == 8'd0)));
    tdc_seen_inc = tdc_seen + 8'd1;
    if (fin_pend) fin_time = pend_b;
    else if (fin_b) fin_time = first_hold;
    else fin_time = w;
  end

  // Next state
  always_comb begin
    mode_next = mode;
    unique case (mode)
      fedbx_pkg::MODE_HUNT: begin
        if (tdc_open) begin
          mode_next = (tdc_limit == 8'd0) ? fedbx_pkg::MODE_HUNT : fedbx_pkg::MODE_TDC;
        end else if (hdr) begin
          mode_next = fedbx_pkg::MODE_EVENT;
        end
      end
      fedbx_pkg::MODE_TDC: begin
        if (stream) begin
          if (w[31:28] == fedbx_pkg::TRAILER_NIB) mode_next = fedbx_pkg::MODE_SKIP;
          else if (tdc_seen_inc >= tdc_limit) mode_next = fedbx_pkg::MODE_HUNT;
        end
      end
      fedbx_pkg::MODE_SKIP: begin
        if (stream) mode_next = fedbx_pkg::MODE_HUNT;
      end
      fedbx_pkg::MODE_EVENT: begin
        if (finish) mode_next = fedbx_pkg::MODE_HUNT;
      end
      default: mode_next = fedbx_pkg::MODE_HUNT;
    endcase
  end

  // Datapath and job
  always_comb begin
    pair_half_next  = pair_half;
    first_hold_next = first_hold;
    pend_a_next     = pend_a;
    pend_b_next     = pend_b;
    pend_vld_next   = pend_vld;
    prev_a_next     = prev_a;
    prev_b_next     = prev_b;
    tdc_seen_next   = tdc_seen;
    word_cnt_next   = word_cnt;
    cur_xing_next   = cur_xing;
    cur_evt_next    = cur_evt;
    last_time_next  = last_time;
    time_off_next   = time_off;
    d0 = '0;
    d1 = '0;
    for (int k = 0; k < 5; k++) cnt_next[k] = cnt[k];

    if (stream) begin
      if (mode == fedbx_pkg::MODE_TDC) begin
        tdc_seen_next = tdc_seen_inc;
      end else if (ev_pend) begin
        pend_vld_next = 1'b0;
        if (pend_a != prev_a) d0 = fedbx_pkg::decode_word(pend_a);
        if (!fin_pend && (pend_b != prev_b)) d1 = fedbx_pkg::decode_word(pend_b);
        if (fin_pend) begin
          word_cnt_next = sat_cnt(word_cnt, 3'd1);
        end else begin
          word_cnt_next   = sat_cnt(word_cnt, 3'd2);
          prev_a_next     = pend_a;
          prev_b_next     = pend_b;
          first_hold_next = w;
          pair_half_next  = 1'b1;
        end
      end else if (mode != fedbx_pkg::MODE_SKIP) begin
        if (!pair_half) begin
          first_hold_next = w;
          pair_half_next  = 1'b1;
        end else begin
          pair_half_next = 1'b0;
          if (mode == fedbx_pkg::MODE_EVENT && !finish) begin
            pend_a_next   = first_hold;
            pend_b_next   = w;
            pend_vld_next = 1'b1;
          end
          if (tdc_open) tdc_seen_next = 8'd0;
          if (hdr) begin
            if (w[31:24] == fedbx_pkg::HEADER_BYTE) begin
              cur_evt_next  = w[23:0];
              cur_xing_next = first_hold[31:20];
            end else begin
              cur_evt_next  = first_hold[23:0];
              cur_xing_next = w[31:20];
            end
            for (int k = 0; k < 5; k++) cnt_next[k] = '0;
            word_cnt_next = '0;
            prev_a_next   = first_hold;
            prev_b_next   = w;
            pend_vld_next = 1'b0;
          end
        end
      end
    end

    inc[0] = 3'(d0.hit) + 3'(d1.hit);
    inc[1] = 3'(d0.spa) + 3'(d1.spa);
    inc[2] = 3'(d0.spb) + 3'(d1.spb);
    inc[3] = 3'(d0.spc) + 3'(d1.spc);
    inc[4] = 3'(d0.err) + 3'(d1.err);
    if (ev_pend && stream) begin
      for (int k = 0; k < 5; k++) cnt_next[k] = sat_cnt(cnt[k], inc[k]);
    end

    if (finish) begin
      if ($signed(fin_time) < $signed(last_time)) time_off_next = time_off + wrap_step;
      last_time_next = fin_time;
      pair_half_next = 1'b0;
      pend_vld_next  = 1'b0;
    end

    push = (take && (item.opcode == fedbx_pkg::OP_READ)) || finish;
    job  = '0;
    if (finish) begin
      job.kind            = fedbx_pkg::KIND_EVENT;
      job.crossing        = cur_xing;
      job.event_number    = cur_evt;
      job.hit_count       = 16'(cnt_next[0]);
      job.special_a_count = 16'(cnt_next[1]);
      job.special_b_count = 16'(cnt_next[2]);
      job.special_c_count = 16'(cnt_next[3]);
      job.error_count     = 16'(cnt_next[4]);
      job.data_word_count = 16'(word_cnt_next);
      job.event_time      = fin_time + time_off_next;
      job.hist_hits       = 32'(cnt_next[0]);
    end else begin
      job.kind     = fedbx_pkg::KIND_READ;
      job.crossing = item.bin_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= fedbx_pkg::MODE_HUNT;
      pair_half <= 1'b0;
      first_hold <= '0;
      pend_a    <= '0;
      pend_b    <= '0;
      pend_vld  <= 1'b0;
      prev_a    <= '0;
      prev_b    <= '0;
      tdc_seen  <= '0;
      for (int k = 0; k < 5; k++) cnt[k] <= '0;
      word_cnt  <= '0;
      cur_xing  <= '0;
      cur_evt   <= '0;
      last_time <= fedbx_pkg::LAST_TIME_RST;
      time_off  <= '0;
      tdc_limit <= fedbx_pkg::TDC_LIMIT_RST;
      wrap_step <= fedbx_pkg::WRAP_STEP_RST;
    end else begin
      mode      <= mode_next;
      pair_half <= pair_half_next;
      first_hold <= first_hold_next;
      pend_a    <= pend_a_next;
      pend_b    <= pend_b_next;
      pend_vld  <= pend_vld_next;
      prev_a    <= prev_a_next;
      prev_b    <= prev_b_next;
      tdc_seen  <= tdc_seen_next;
      for (int k = 0; k < 5; k++) cnt[k] <= cnt_next[k];
      word_cnt  <= word_cnt_next;
      cur_xing  <= cur_xing_next;
      cur_evt   <= cur_evt_next;
      last_time <= last_time_next;
      time_off  <= time_off_next;
      if (cfg_we) begin
        if (cfg_index == fedbx_pkg::REG_TDC_SCAN_LIMIT) tdc_limit <= cfg_data[7:0];
        else wrap_step <= cfg_data;
      end
    end
  end

endmodule

// ----- rtl/fedbx_queue.sv -----
// Short job queue between the front and back parts.
// Depends on fedbx_pkg.
module fedbx_queue #(
  parameter int DEPTH = fedbx_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fedbx_pkg::job_t   push_data,
  input  logic              pop,
  output fedbx_pkg::job_t   pop_data,
  output fedbx_pkg::q_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  fedbx_pkg::job_t slots [DEPTH];
  logic [PW-1:0] head, tail;
  logic [NW-1:0] fill;

  assign pop_data   = slots[head];
  assign stat.full  = (fill == NW'(DEPTH));
  assign stat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) slots[tail] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (push) tail <= (tail == PW'(DEPTH - 1)) ? '0 : tail + PW'(1);
      if (pop)  head <= (head == PW'(DEPTH - 1)) ? '0 : head + PW'(1);
      if (push && !pop) fill <= fill + NW'(1);
      else if (pop && !push) fill <= fill - NW'(1);
    end
  end

endmodule

// ----- rtl/fedbx_back.sv -----
// Back part: per-crossing histogram memories, bin readback and the result register.
// Depends on fedbx_pkg.
module fedbx_back #(
  parameter int CROSSING_BINS = fedbx_pkg::CROSSING_BINS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  output logic             pop,
  input  fedbx_pkg::job_t  job,
  output logic             clearing,
  output logic             out_valid,
  input  logic             out_ready,
  output fedbx_pkg::res_t  out_data
);

  localparam int BW = $clog2(CROSSING_BINS);

  logic [31:0] ev_mem  [CROSSING_BINS];
  logic [31:0] hit_mem [CROSSING_BINS];

  logic [BW-1:0]   clr_addr;
  logic            b_vld, b_rng, b_adv;
  fedbx_pkg::job_t b_job;
  logic [BW-1:0]   b_addr, pop_addr;
  logic            pop_rng;
  logic [31:0]     rd_ev, rd_hit, cur_ev, cur_hit, new_ev, new_hit;
  logic            fwd;
  logic [31:0]     fwd_ev, fwd_hit;
  logic [32:0]     hit_sum;
  logic            wr_en;
  fedbx_pkg::res_t res;

  assign b_adv    = b_vld && (!out_valid || out_ready);
  assign pop      = !clearing && !q_empty && (!b_vld || b_adv);
  assign pop_addr = job.crossing[BW-1:0];
  assign pop_rng  = ({1'b0, job.crossing} < 13'(CROSSING_BINS));

  always_comb begin
    cur_ev  = fwd ? fwd_ev  : rd_ev;
    cur_hit = fwd ? fwd_hit : rd_hit;
    new_ev  = (cur_ev == fedbx_pkg::ALL_ONES) ? cur_ev : cur_ev + 32'd1;
    hit_sum = {1'b0, cur_hit} + {1'b0, b_job.hist_hits};
    new_hit = hit_sum[32] ? fedbx_pkg::ALL_ONES : hit_sum[31:0];
    wr_en   = b_adv && (b_job.kind == fedbx_pkg::KIND_EVENT) && b_rng;

    res = '0;
    res.result_kind = b_job.kind;
    res.crossing    = b_job.crossing;
    if (b_job.kind == fedbx_pkg::KIND_EVENT) begin
      res.event_number    = b_job.event_number;
      res.hit_count       = b_job.hit_count;
      res.special_a_count = b_job.special_a_count;
      res.special_b_count = b_job.special_b_count;
      res.special_c_count = b_job.special_c_count;
      res.error_count     = b_job.error_count;
      res.data_word_count = b_job.data_word_count;
      res.event_time      = b_job.event_time;
    end else if (b_rng) begin
      res.bin_events = cur_ev;
      res.bin_hits   = cur_hit;
    end
  end

  // Histogram storage: clearing sweep, else read-modify-write
  always_ff @(posedge clk) begin
    if (clearing) begin
      ev_mem[clr_addr]  <= '0;
      hit_mem[clr_addr] <= '0;
    end else if (wr_en) begin
      ev_mem[b_addr]  <= new_ev;
      hit_mem[b_addr] <= new_hit;
    end
    if (pop) begin
      rd_ev  <= ev_mem[pop_addr];
      rd_hit <= hit_mem[pop_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_job   <= job;
      b_addr  <= pop_addr;
      b_rng   <= pop_rng;
      fwd_ev  <= new_ev;
      fwd_hit <= new_hit;
    end
    if (b_adv) out_data <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      b_vld     <= 1'b0;
      fwd       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_addr == BW'(CROSSING_BINS - 1)) clearing <= 1'b0;
        else clr_addr <= clr_addr + BW'(1);
      end
      if (pop) begin
        b_vld <= 1'b1;
        fwd   <= wr_en && (b_addr == pop_addr);
      end else if (b_adv) begin
        b_vld <= 1'b0;
      end
      if (b_adv) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/fedbx_checker.sv -----
// Port-level checks for the event deframer, attached by bind.
// Depends on fedbx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fedbx_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input fedbx_pkg::res_t out_data
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `ASSERT_NEXT_ANY(a_clear_after_rst, clk, rst, !in_ready)
  `ASSERT_IMPLY(a_read_zero, clk, rst, out_valid && out_data.result_kind == fedbx_pkg::KIND_READ, out_data.event_time == 32'd0 && out_data.hit_count == 16'd0 && out_data.event_number == 24'd0)
  `ASSERT_IMPLY(a_event_zero, clk, rst, out_valid && out_data.result_kind == fedbx_pkg::KIND_EVENT, out_data.bin_events == 32'd0 && out_data.bin_hits == 32'd0)

endmodule

bind fed_event_deframer_bx_histogram fedbx_checker u_chk (.*);

// ----- test/tb_fed_event_deframer_bx_histogram.sv -----
// Self-checking testbench for fed_event_deframer_bx_histogram.
// Depends on fedbx_pkg; predicts event and bin-read results and checks every one.
`timescale 1ns / 100ps

class deframer_scoreboard;
  bit [7:0]  scan_limit;
  bit [31:0] wrap_step;
  fedbx_pkg::mode_t mode;
  bit        half;
  bit [31:0] held_word;
  bit [63:0] pend_pair;
  bit        pend_ok;
  bit [63:0] prev_pair;
  bit [7:0]  tdc_seen;
  bit [15:0] counts[5];
  bit [15:0] words;
  bit [11:0] cur_bx;
  bit [23:0] cur_evt;
  bit [31:0] last_t;
  bit [31:0] t_offset;
  bit [31:0] bin_evts[4096];
  bit [31:0] bin_hit_sum[4096];
  fedbx_pkg::res_t expected_q[$];
  int        errors;

  function new();
    scan_limit = fedbx_pkg::TDC_LIMIT_RST;
    wrap_step  = fedbx_pkg::WRAP_STEP_RST;
    mode       = fedbx_pkg::MODE_HUNT;
    half       = 0;
    held_word  = '0;
    pend_pair  = '0;
    pend_ok    = 0;
    prev_pair  = '0;
    tdc_seen   = '0;
    foreach (counts[k]) counts[k] = '0;
    words      = '0;
    cur_bx     = '0;
    cur_evt    = '0;
    last_t     = fedbx_pkg::LAST_TIME_RST;
    t_offset   = '0;
    foreach (bin_evts[k]) begin
      bin_evts[k]    = '0;
      bin_hit_sum[k] = '0;
    end
    errors = 0;
  endfunction

  function void set_reg(bit idx, bit [31:0] v);
    if (idx == fedbx_pkg::REG_TDC_SCAN_LIMIT) scan_limit = v[7:0];
    else wrap_step = v;
  endfunction

  function void bump(int k, int n);
    int s;
    s = int'(counts[k]) + n;
    counts[k] = (s > 65535) ? 16'hffff : s[15:0];
  endfunction

  // Sort one data word into hit, special or error counts.
  function void classify(bit [31:0] w);
    bit [5:0] chan;
    bit [4:0] chip;
    chan = w[31:26];
    chip = w[25:21];
    if (w[27:0] == 0) bump(4, 1);
    else if (chip > 25) begin
      if (w == 32'hffffffff) bump(4, 1);
      else if (chip == 26 || chip == 27) bump(1, 1);
      else if (chip == 29) bump(2, 1);
      else if (chip == 31) bump(3, 1);
      else bump(4, 1);
    end else if (chan > 0 && chan < 37) begin
      if (chip >= 1 && chip <= 3) bump(0, 1);
      else bump(4, 1);
    end else bump(4, 2);
  endfunction

  function void add_words(int n);
    int s;
    s = int'(words) + n;
    words = (s > 65535) ? 16'hffff : s[15:0];
  endfunction

  function void close_event(bit [31:0] t);
    fedbx_pkg::res_t r;
    bit [32:0] s;
    if ($signed(t) < $signed(last_t)) t_offset += wrap_step;
    last_t = t;
    bin_evts[cur_bx] = (bin_evts[cur_bx] == 32'hffffffff) ? 32'hffffffff
                                                          : bin_evts[cur_bx] + 1;
    s = {1'b0, bin_hit_sum[cur_bx]} + counts[0];
    bin_hit_sum[cur_bx] = s[32] ? 32'hffffffff : s[31:0];
    r = '0;
    r.result_kind     = fedbx_pkg::KIND_EVENT;
    r.crossing        = cur_bx;
    r.event_number    = cur_evt;
    r.hit_count       = counts[0];
    r.special_a_count = counts[1];
    r.special_b_count = counts[2];
    r.special_c_count = counts[3];
    r.error_count     = counts[4];
    r.data_word_count = words;
    r.event_time      = t + t_offset;
    expected_q.push_back(r);
    mode    = fedbx_pkg::MODE_HUNT;
    half    = 0;
    pend_ok = 0;
  endfunction

  // Note one accepted input item and queue any result it causes.
  function void note_input(fedbx_pkg::in_t it);
    fedbx_pkg::res_t r;
    bit [31:0] w, a, b;
    w = it.stream_word;
    if (it.opcode == fedbx_pkg::OP_READ) begin
      r = '0;
      r.result_kind = fedbx_pkg::KIND_READ;
      r.crossing    = it.bin_index;
      r.bin_events  = bin_evts[it.bin_index];
      r.bin_hits    = bin_hit_sum[it.bin_index];
      expected_q.push_back(r);
      return;
    end
    if (mode == fedbx_pkg::MODE_TDC) begin
      tdc_seen++;
      if (w[31:28] == fedbx_pkg::TRAILER_NIB) mode = fedbx_pkg::MODE_SKIP;
      else if (tdc_seen >= scan_limit) mode = fedbx_pkg::MODE_HUNT;
      return;
    end
    if (mode == fedbx_pkg::MODE_SKIP) begin
      mode = fedbx_pkg::MODE_HUNT;
      return;
    end
    if (mode == fedbx_pkg::MODE_EVENT && pend_ok) begin
      pend_ok = 0;
      if (pend_pair[63:32] != prev_pair[63:32]) classify(pend_pair[63:32]);
      if (w[31:24] == fedbx_pkg::TRAILER_BYTE) begin
        add_words(1);
        close_event(pend_pair[31:0]);
        return;
      end
      if (pend_pair[31:0] != prev_pair[31:0]) classify(pend_pair[31:0]);
      add_words(2);
      prev_pair = pend_pair;
      held_word = w;
      half = 1;
      return;
    end
    if (!half) begin
      held_word = w;
      half = 1;
      return;
    end
    half = 0;
    a = held_word;
    b = w;
    if (mode == fedbx_pkg::MODE_EVENT) begin
      if (b[31:24] == fedbx_pkg::TRAILER_BYTE) close_event(a);
      else if (a[31:24] == fedbx_pkg::TRAILER_BYTE) close_event(b);
      else begin
        pend_pair = {a, b};
        pend_ok   = 1;
      end
      return;
    end
    if (a == fedbx_pkg::TDC_MARK && b == fedbx_pkg::TDC_MARK) begin
      tdc_seen = 0;
      mode = (scan_limit == 0) ? fedbx_pkg::MODE_HUNT : fedbx_pkg::MODE_TDC;
      return;
    end
    if ((b[31:24] == fedbx_pkg::HEADER_BYTE && a[7:0] == 0) ||
        (a[31:24] == fedbx_pkg::HEADER_BYTE && b[7:0] == 0)) begin
      if (b[31:24] == fedbx_pkg::HEADER_BYTE) begin
        cur_evt = b[23:0];
        cur_bx  = a[31:20];
      end else begin
        cur_evt = a[23:0];
        cur_bx  = b[31:20];
      end
      foreach (counts[k]) counts[k] = '0;
      words     = '0;
      prev_pair = {a, b};
      pend_ok   = 0;
      mode      = fedbx_pkg::MODE_EVENT;
    end
  endfunction

  function void check_result(fedbx_pkg::res_t got);
    fedbx_pkg::res_t e;
    if (expected_q.size() == 0) begin
      $error("unexpected result: %p", got);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (got.result_kind != e.result_kind) begin
      $error("result_kind exp %0d got %0d", e.result_kind, got.result_kind); errors++;
    end
    if (got.crossing != e.crossing) begin
      $error("crossing exp %0d got %0d", e.crossing, got.crossing); errors++;
    end
    if (got.event_number != e.event_number) begin
      $error("event_number exp %0h got %0h", e.event_number, got.event_number); errors++;
    end
    if (got.hit_count != e.hit_count) begin
      $error("hit_count exp %0d got %0d", e.hit_count, got.hit_count); errors++;
    end
    if (got.special_a_count != e.special_a_count) begin
      $error("special_a_count exp %0d got %0d", e.special_a_count, got.special_a_count);
      errors++;
    end
    if (got.special_b_count != e.special_b_count) begin
      $error("special_b_count exp %0d got %0d", e.special_b_count, got.special_b_count);
      errors++;
    end
    if (got.special_c_count != e.special_c_count) begin
      $error("special_c_count exp %0d got %0d", e.special_c_count, got.special_c_count);
      errors++;
    end
    if (got.error_count != e.error_count) begin
      $error("error_count exp %0d got %0d", e.error_count, got.error_count); errors++;
    end
    if (got.data_word_count != e.data_word_count) begin
      $error("data_word_count exp %0d got %0d", e.data_word_count, got.data_word_count);
      errors++;
    end
    if (got.event_time != e.event_time) begin
      $error("event_time exp %0h got %0h", e.event_time, got.event_time); errors++;
    end
    if (got.bin_events != e.bin_events) begin
      $error("bin_events exp %0d got %0d", e.bin_events, got.bin_events); errors++;
    end
    if (got.bin_hits != e.bin_hits) begin
      $error("bin_hits exp %0d got %0d", e.bin_hits, got.bin_hits); errors++;
    end
  endfunction
endclass

module tb_fed_event_deframer_bx_histogram;
  localparam int CYCLE_LIMIT = 400000;

  logic  clk = 0;
  logic  rst = 1;
  logic  cfg_we = 0;
  logic  cfg_index = 0;
  logic  [31:0] cfg_data = '0;
  logic  in_valid = 0;
  logic  in_ready;
  fedbx_pkg::in_t  in_data = '0;
  logic  out_valid;
  logic  out_ready = 0;
  fedbx_pkg::res_t out_data;

  deframer_scoreboard bx_model = new();
  bit    quiet_tail = 0;
  int    cycle_count = 0;
  int    n_sent = 0;

  fed_event_deframer_bx_histogram u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Time-out guard: the clearing pass plus the worst stalls sit well inside this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) bx_model.check_result(out_data);
  end

  // Result side: stall in random bursts, none in the quiet tail.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 7);
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk);
    end
  end

  // Offer one item and hold it until accepted; the predictor sees it on acceptance.
  // Valid stays high into the next item unless an idle burst drops it.
  task automatic send_item(fedbx_pkg::in_t it);
    int n;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 7);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    bx_model.note_input(it);
    n_sent++;
  endtask

  task automatic send_word(bit [31:0] w);
    fedbx_pkg::in_t it;
    it = '0;
    it.opcode = fedbx_pkg::OP_STREAM;
    it.stream_word = w;
    it.bin_index = 12'($urandom);
    send_item(it);
  endtask

  task automatic read_bin(bit [11:0] b);
    fedbx_pkg::in_t it;
    it = '0;
    it.opcode = fedbx_pkg::OP_READ;
    it.bin_index = b;
    it.stream_word = $urandom;
    send_item(it);
  endtask

  // Drop valid, wait for all results, then let the pipeline drain.
  task automatic drain();
    in_valid <= 0;
    while (bx_model.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(bit idx, bit [31:0] v);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    bx_model.set_reg(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Data word with a mix of hits, specials and errors.
  function automatic bit [31:0] data_word();
    bit [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 6))
      0: w[31:21] = {6'($urandom_range(1, 36)), 5'($urandom_range(1, 3))};
      1: w[25:21] = 5'($urandom_range(26, 31));
      2: w[27:0]  = '0;
      3: w = 32'hffffffff;
      default: ;
    endcase
    if (w[31:24] == fedbx_pkg::TRAILER_BYTE) w[31:24] = 8'h11;
    return w;
  endfunction

  // One well-formed event: header pair, data pairs and a trailer in one of its forms.
  task automatic send_event(int npairs);
    bit [31:0] hdr, bxw, a, b, tr;
    bit [11:0] bx;
    bx  = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
    hdr = {fedbx_pkg::HEADER_BYTE, 24'($urandom)};
    bxw = {bx, 20'($urandom)};
    bxw[7:0] = 0;
    if ($urandom_range(0, 1)) begin
      send_word(bxw); send_word(hdr);
    end else begin
      hdr[7:0] = 0; send_word(hdr); send_word(bxw);
    end
    a = data_word(); b = data_word();
    for (int k = 0; k < npairs; k++) begin
      if ($urandom_range(0, 3) != 0) begin
        a = data_word(); b = data_word();
      end
      send_word(a); send_word(b);
    end
    tr = {fedbx_pkg::TRAILER_BYTE, 24'($urandom)};
    case ($urandom_range(0, 2))
      0: begin send_word($urandom); send_word(tr); end
      1: begin send_word(tr); send_word($urandom); end
      default: send_word(tr);
    endcase
  endtask

  task automatic send_tdc_block(int len);
    send_word(fedbx_pkg::TDC_MARK); send_word(fedbx_pkg::TDC_MARK);
    for (int k = 0; k < len; k++) send_word(data_word());
    if ($urandom_range(0, 1)) begin
      send_word({fedbx_pkg::TRAILER_NIB, 28'($urandom)});
      send_word($urandom);
    end
  endtask

  initial begin
    bit reconfigured;
    reconfigured = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: decoder corners, both trailer forms, TDC skipping, bin extremes.
    send_event(0);
    send_word(32'h0000_0000); send_word(32'h5000_0001);
    send_word(32'hffff_ffff); send_word(32'h0400_0000);
    send_word(32'h0460_0001); send_word(32'h9240_0001);
    send_word(32'h03a0_0001); send_word(32'hfc00_0001);
    send_word(32'ha000_0005);
    send_tdc_block(3);
    send_event(2);
    read_bin(12'd0); read_bin(12'hfff);
    drain();

    // Tight TDC limit and zero wrap step, then zero limit and the largest step.
    write_reg(fedbx_pkg::REG_TDC_SCAN_LIMIT, 32'd1);
    write_reg(fedbx_pkg::REG_TIME_WRAP_STEP, 32'd0);
    send_tdc_block(4);
    send_event(1);
    drain();
    write_reg(fedbx_pkg::REG_TDC_SCAN_LIMIT, 32'd0);
    write_reg(fedbx_pkg::REG_TIME_WRAP_STEP, 32'hffffffff);
    send_tdc_block(2);
    send_event(1); send_event(3);
    drain();
    write_reg(fedbx_pkg::REG_TDC_SCAN_LIMIT, 32'd255);
    write_reg(fedbx_pkg::REG_TIME_WRAP_STEP, 32'd86400000);

    while (n_sent < 1130) begin
      if (n_sent > 1000) quiet_tail = 1;
      case ($urandom_range(0, 9))
        0: send_word($urandom);
        1: read_bin(12'($urandom_range(0, 15)));
        2: send_tdc_block($urandom_range(0, 6));
        3: read_bin(12'($urandom));
        default: send_event($urandom_range(0, 6));
      endcase
      if (!reconfigured && n_sent >= 500) begin
        drain();
        write_reg(fedbx_pkg::REG_TDC_SCAN_LIMIT, 32'($urandom_range(1, 8)));
        write_reg(fedbx_pkg::REG_TIME_WRAP_STEP, $urandom);
        reconfigured = 1;
      end
    end
    for (int k = 0; k < 16; k++) read_bin(12'(k));
    quiet_tail = 1;
    drain();
    repeat (20) @(posedge clk);
    if (bx_model.errors == 0 && bx_model.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
